>>> design/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg: shared types, constants and arithmetic helpers
// Widths, register map, the configuration and result bundles, and the
// saturating and averaging functions used by the motion reversal tracker.
// ----------------------------------------------------------------------------
package mrt_pkg;

  // Core widths.
  localparam int POS_W     = 32;  // relative position and extremes
  localparam int DELTA_W   = 16;  // sensor delta fields
  localparam int FRAC_W    = 8;   // fraction bits of the speed averages
  localparam int AVG_W     = 24;  // speed average field width
  localparam int EXT_W     = 32;  // extent field width
  localparam int MARGIN_W  = 16;
  localparam int SHIFT_W   = 4;

  // Derived widths.
  localparam int SUM_W  = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 1;
  localparam int NEG_W  = POS_W + 1;
  localparam int XW     = (NEG_W > EXT_W) ? NEG_W : EXT_W;
  localparam int CMP_W  = ((POS_W > MARGIN_W + 1) ? POS_W : MARGIN_W + 1) + 1;
  localparam int TGT_W  = DELTA_W + FRAC_W;
  localparam int TXW    = (TGT_W > AVG_W) ? TGT_W : AVG_W;

  // Saturation limits.
  localparam logic signed [SUM_W-1:0] POS_HI =
    {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_LO =
    {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
  localparam logic signed [XW-1:0] EXT_HI =
    {{(XW-EXT_W+1){1'b0}}, {(EXT_W-1){1'b1}}};
  localparam logic signed [XW-1:0] EXT_LO =
    {{(XW-EXT_W+1){1'b1}}, {(EXT_W-1){1'b0}}};
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_MARGIN = 2'd0,
    REG_AVG_SHIFT = 2'd1,
    REG_DECAY_SHIFT = 2'd2
  } reg_idx_e;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(64);
  localparam logic [SHIFT_W-1:0]  AVG_SHIFT_RST = SHIFT_W'(8);
  localparam logic [SHIFT_W-1:0]  DECAY_SHIFT_RST = SHIFT_W'(5);

  // Item kinds.
  localparam logic OP_MOTION = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic [SHIFT_W-1:0]  avg_shift;
    logic [SHIFT_W-1:0]  decay_shift;
  } cfg_t;

  typedef struct packed {
    logic                    reversed;
    logic                    rising_now;
    logic signed [EXT_W-1:0] extent_x;
    logic signed [EXT_W-1:0] extent_y;
    logic [AVG_W-1:0]        speed_x_avg;
    logic [AVG_W-1:0]        speed_y_avg;
  } res_t;

  // Clamp a position-plus-delta sum to the signed position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_HI) begin
      r = POS_HI[POS_W-1:0];
    end else if (v < POS_LO) begin
      r = POS_LO[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Clamp a (possibly negated) position to the extent field range.
  function automatic logic signed [EXT_W-1:0] sat_ext(input logic signed [NEG_W-1:0] v);
    logic signed [XW-1:0] w;
    logic signed [EXT_W-1:0] r;
    w = XW'(v);
    if (w > EXT_HI) begin
      r = EXT_HI[EXT_W-1:0];
    end else if (w < EXT_LO) begin
      r = EXT_LO[EXT_W-1:0];
    end else begin
      r = w[EXT_W-1:0];
    end
    return r;
  endfunction

  // Exponential average of the delta magnitude in fixed point.
  function automatic logic [AVG_W-1:0] avg_update(input logic [AVG_W-1:0] avg,
                                                  input logic signed [DELTA_W-1:0] d,
                                                  input logic [SHIFT_W-1:0] sh);
    logic [DELTA_W-1:0] mag;
    logic [TXW-1:0]     tw;
    logic [AVG_W-1:0]   tgt;
    logic [AVG_W-1:0]   a0;
    logic [AVG_W-1:0]   r;
    mag = d[DELTA_W-1] ? DELTA_W'(-d) : d;
    tw  = TXW'(mag) << FRAC_W;
    tgt = (tw > TXW'(AVG_MAX)) ? AVG_MAX : tw[AVG_W-1:0];
    a0  = (avg == '0) ? tgt : avg;
    if (tgt >= a0) begin
      r = a0 + ((tgt - a0) >> sh);
    end else begin
      r = a0 - ((a0 - tgt) >> sh);
    end
    return r;
  endfunction

endpackage

>>> design/mrt_cfg.sv
// ----------------------------------------------------------------------------
// mrt_cfg: configuration register file
// APB-style register block holding the reversal margin and the two shift
// amounts of the speed averages.
// ----------------------------------------------------------------------------
module mrt_cfg
  import mrt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MARGIN:      cfg_d.margin      = pwdata[MARGIN_W-1:0];
        REG_AVG_SHIFT:   cfg_d.avg_shift   = pwdata[SHIFT_W-1:0];
        REG_DECAY_SHIFT: cfg_d.decay_shift = pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin      <= MARGIN_RST;
      cfg_q.avg_shift   <= AVG_SHIFT_RST;
      cfg_q.decay_shift <= DECAY_SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_MARGIN:      prdata = APB_DW'(cfg_q.margin);
      REG_AVG_SHIFT:   prdata = APB_DW'(cfg_q.avg_shift);
      REG_DECAY_SHIFT: prdata = APB_DW'(cfg_q.decay_shift);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> design/mrt_core.sv
// ----------------------------------------------------------------------------
// mrt_core: tracking state and single-pass step logic
// Holds positions, extremes, direction and speed averages, and computes the
// result of one item combinationally; the state advances when step_i is high.
// ----------------------------------------------------------------------------
module mrt_core
  import mrt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      step_i,
  input  logic                      op_i,
  input  logic signed [DELTA_W-1:0] dx_i,
  input  logic signed [DELTA_W-1:0] dy_i,
  output res_t                      res_o
);

  logic signed [POS_W-1:0] rel_x_q, rel_y_q, min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [POS_W-1:0] rel_x_d, rel_y_d, min_x_d, max_x_d, min_y_d, max_y_d;
  logic                    rising_q, rising_d, started_q, started_d;
  logic [AVG_W-1:0]        avg_x_q, avg_x_d, avg_y_q, avg_y_d;

  logic signed [POS_W-1:0] nx, ny, mnx, mxx, mny, mxy;
  logic signed [DELTA_W:0] dsum;
  logic                    dir;
  logic signed [CMP_W-1:0] lo_thr, hi_thr, ny_w;
  logic                    rev_up, rev_dn;

  // Position update with saturation, then extremes.
  always_comb begin
    nx  = sat_pos(SUM_W'(rel_x_q) + SUM_W'(dx_i));
    ny  = sat_pos(SUM_W'(rel_y_q) - SUM_W'(dy_i));
    mnx = (nx < min_x_q) ? nx : min_x_q;
    mxx = (nx > max_x_q) ? nx : max_x_q;
    mny = (ny < min_y_q) ? ny : min_y_q;
    mxy = (ny > max_y_q) ? ny : max_y_q;
  end

  // Direction: the first motion sample sets it from the sign of dx + dy.
  assign dsum = (DELTA_W+1)'(dx_i) + (DELTA_W+1)'(dy_i);
  assign dir  = started_q ? rising_q : !dsum[DELTA_W];

  // Reversal tests against the extremes with the hysteresis margin.
  assign ny_w   = CMP_W'(ny);
  assign lo_thr = CMP_W'(mny) + CMP_W'($signed({1'b0, cfg_i.margin}));
  assign hi_thr = CMP_W'(mxy) - CMP_W'($signed({1'b0, cfg_i.margin}));
  assign rev_up = !dir && (ny_w > lo_thr);
  assign rev_dn = dir && (ny_w < hi_thr);

  // Next state and result.
  always_comb begin
    rel_x_d   = rel_x_q;
    rel_y_d   = rel_y_q;
    min_x_d   = min_x_q;
    max_x_d   = max_x_q;
    min_y_d   = min_y_q;
    max_y_d   = max_y_q;
    rising_d  = rising_q;
    started_d = started_q;
    avg_x_d   = avg_x_q;
    avg_y_d   = avg_y_q;
    res_o     = '0;
    if (op_i == OP_TICK) begin
      avg_y_d = avg_y_q - (avg_y_q >> cfg_i.decay_shift);
    end else begin
      rel_x_d   = nx;
      rel_y_d   = ny;
      min_x_d   = mnx;
      max_x_d   = mxx;
      min_y_d   = mny;
      max_y_d   = mxy;
      started_d = 1'b1;
      rising_d  = dir;
      if (rev_up) begin
        rising_d        = 1'b1;
        res_o.reversed  = 1'b1;
        res_o.extent_x  = sat_ext(-NEG_W'(mnx));
        res_o.extent_y  = sat_ext(-NEG_W'(mny));
      end else if (rev_dn) begin
        rising_d        = 1'b0;
        res_o.reversed  = 1'b1;
        res_o.extent_x  = sat_ext(NEG_W'(mxx));
        res_o.extent_y  = sat_ext(NEG_W'(mxy));
      end
      if (rev_up || rev_dn) begin
        rel_x_d = '0;
        rel_y_d = '0;
        min_x_d = '0;
        max_x_d = '0;
        min_y_d = '0;
        max_y_d = '0;
      end
      avg_x_d = avg_update(avg_x_q, dx_i, cfg_i.avg_shift);
      avg_y_d = avg_update(avg_y_q, dy_i, cfg_i.avg_shift);
    end
    res_o.rising_now  = rising_d;
    res_o.speed_x_avg = avg_x_d;
    res_o.speed_y_avg = avg_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_x_q   <= '0;
      rel_y_q   <= '0;
      min_x_q   <= '0;
      max_x_q   <= '0;
      min_y_q   <= '0;
      max_y_q   <= '0;
      rising_q  <= 1'b0;
      started_q <= 1'b0;
      avg_x_q   <= '0;
      avg_y_q   <= '0;
    end else if (step_i) begin
      rel_x_q   <= rel_x_d;
      rel_y_q   <= rel_y_d;
      min_x_q   <= min_x_d;
      max_x_q   <= max_x_d;
      min_y_q   <= min_y_d;
      max_y_q   <= max_y_d;
      rising_q  <= rising_d;
      started_q <= started_d;
      avg_x_q   <= avg_x_d;
      avg_y_q   <= avg_y_d;
    end
  end

endmodule

>>> design/motion_reversal_tracker.sv
// ----------------------------------------------------------------------------
// motion_reversal_tracker: sensor motion tracking with reversal detection
// Each item passes the input register and then the result register.
// Throughput: one item per cycle unless the master side stalls; the step logic
// between the two registers updates all tracking state combinationally.
// Reset: asynchronous, active low; clears tracking state, empties both
// registers and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module motion_reversal_tracker
  import mrt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // delta_x[15:0], delta_y[31:16]
  input  logic [0:0]        s_axis_tuser,   // op[0]
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [111:0]      m_axis_tdata,   // extent_x[31:0], extent_y[63:32],
                                            // speed_x_avg[87:64],
                                            // speed_y_avg[111:88]
  output logic [1:0]        m_axis_tuser,   // reversed[0], rising_now[1]
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t                      cfg;
  res_t                      res;
  logic                      in_v_q, out_v_q;
  logic                      in_load, out_load;
  logic                      op_q;
  logic signed [DELTA_W-1:0] dx_q, dy_q;
  res_t                      out_q;

  mrt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Stage handshake: the result register frees the input register.
  assign out_load      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  mrt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_v_q && out_load),
    .op_i   (op_q),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .res_o  (res)
  );

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (out_load)      out_v_q <= in_v_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q <= s_axis_tuser[0];
      dx_q <= s_axis_tdata[DELTA_W-1:0];
      dy_q <= s_axis_tdata[2*DELTA_W-1:DELTA_W];
    end
    if (out_load && in_v_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.speed_y_avg, out_q.speed_x_avg,
                          out_q.extent_y, out_q.extent_x};
  assign m_axis_tuser  = {out_q.rising_now, out_q.reversed};

endmodule

>>> design/mrt_checker.sv
// ----------------------------------------------------------------------------
// mrt_checker: port-level assertions for the motion reversal tracker
// Watches the stream ports and is attached to the top level by a bind.
// ----------------------------------------------------------------------------
module mrt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A result without a reversal carries zero extents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
    else $error("extent nonzero without reversal");

  // Extents of a finished sweep are never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[31] && !m_axis_tdata[63])
    else $error("negative sweep extent");

  // An empty result register always lets the input side move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind motion_reversal_tracker mrt_checker u_mrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> dv/motion_reversal_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_reversal_tracker_tb: self-checking bench for the motion tracker
// A directed table, constrained-free random strokes and three short full-scale
// sweeps drive the input stream. Every result is checked field by field
// against a typed table row or the in-bench position, reversal and speed model.
// ----------------------------------------------------------------------------
module motion_reversal_tracker_tb;
  import mrt_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction at all
  localparam int DIR_ROWS = 21;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 305;
  localparam int SWEEP_ITEMS = 8;
  localparam int PRINT_CAP = 100;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    logic               op;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    bit                 typed;
    res_t               want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;   // delta_x[15:0], delta_y[31:16]
  logic [0:0]        s_axis_tuser;   // op[0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [111:0]      m_axis_tdata;   // extent_x[31:0], extent_y[63:32],
                                     // speed_x_avg[87:64], speed_y_avg[111:88]
  logic [1:0]        m_axis_tuser;   // reversed[0], rising_now[1]
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  motion_reversal_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Model state: tracking, direction, speed averages and register copy.
  logic signed [31:0] trk_pos_x, trk_pos_y;
  logic signed [31:0] trk_lo_x, trk_hi_x, trk_lo_y, trk_hi_y;
  logic               trk_rising, trk_started;
  logic [23:0]        trk_speed_x, trk_speed_y;
  cfg_t               shadow_cfg;

  res_t sweep_reports_due[$];

  int mismatches = 0;
  int results_seen = 0;
  int reversals_seen = 0;
  int saturated_extents = 0;
  int motion_sent = 0;
  int ticks_sent = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  bit steady_flow = 1'b0;

  // Directed table: extremes of both deltas, both operations, a reversal on
  // the very first sample, margin edges and ticks with junk in the data.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{OP_TICK,   16'sd0,      16'sd0,      1'b1, {1'b0, 1'b0, 32'sd0, 32'sd0, 24'd0, 24'd0}},
    '{OP_MOTION, 16'sd0,      -16'sd100,   1'b1,
      {1'b1, 1'b1, 32'sd0, 32'sd0, 24'd0, 24'd25600}},
    '{OP_TICK,   16'sh1234,   16'sh5678,   1'b1,
      {1'b0, 1'b1, 32'sd0, 32'sd0, 24'd0, 24'd24800}},
    '{OP_MOTION, 16'sh7fff,   16'sh8000,   1'b0, '0},
    '{OP_MOTION, 16'sh8000,   16'sh7fff,   1'b0, '0},
    '{OP_MOTION, 16'sh8000,   16'sh8000,   1'b0, '0},
    '{OP_MOTION, 16'sh7fff,   16'sh7fff,   1'b0, '0},
    '{OP_MOTION, 16'sd0,      16'sd0,      1'b0, '0},
    '{OP_MOTION, -16'sd1,     -16'sd1,     1'b0, '0},
    '{OP_TICK,   16'shffff,   16'shffff,   1'b0, '0},
    '{OP_MOTION, 16'sh5555,   16'shaaaa,   1'b0, '0},
    '{OP_MOTION, 16'shaaaa,   16'sh5555,   1'b0, '0},
    '{OP_MOTION, 16'sd0,      -16'sd64,    1'b0, '0},
    '{OP_MOTION, 16'sd0,      16'sd64,     1'b0, '0},
    '{OP_MOTION, 16'sd0,      16'sd65,     1'b0, '0},
    '{OP_MOTION, 16'sd0,      -16'sd65,    1'b0, '0},
    '{OP_MOTION, 16'sd0,      -16'sd1,     1'b0, '0},
    '{OP_MOTION, 16'sd1,      16'sd1,      1'b0, '0},
    '{OP_TICK,   16'sd0,      16'sd0,      1'b0, '0},
    '{OP_TICK,   16'sd0,      16'sd0,      1'b0, '0},
    '{OP_MOTION, 16'sd100,    16'sd200,    1'b0, '0}
  };

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clamp a wide value to the signed 32-bit range of positions and extents.
  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Next value of one exponential speed average for a motion delta.
  function automatic logic [23:0] speed_average_next(input logic [23:0] avg,
                                                     input longint d,
                                                     input logic [3:0] sh);
    longint target;
    longint acc;
    target = (d < 0 ? -d : d) << 8;
    if (target > 64'hffffff) begin
      target = 64'hffffff;
    end
    acc = avg;
    if (acc == 0) begin
      acc = target;
    end
    if (target >= acc) begin
      acc = acc + ((target - acc) >> sh);
    end else begin
      acc = acc - ((acc - target) >> sh);
    end
    return acc[23:0];
  endfunction

  // Advance the tracking model by one accepted item and form its report.
  function automatic res_t tracker_step(input logic op,
                                        input logic signed [15:0] dx_in,
                                        input logic signed [15:0] dy_in);
    longint dx;
    longint dy;
    longint mg;
    res_t   r;
    r = '0;
    if (op == OP_TICK) begin
      trk_speed_y = trk_speed_y - (trk_speed_y >> shadow_cfg.decay_shift);
    end else begin
      dx = dx_in;
      dy = dy_in;
      mg = longint'(shadow_cfg.margin);
      trk_pos_x = clamp_s32(longint'(trk_pos_x) + dx);
      trk_pos_y = clamp_s32(longint'(trk_pos_y) - dy);
      if (trk_pos_x < trk_lo_x) trk_lo_x = trk_pos_x;
      if (trk_pos_x > trk_hi_x) trk_hi_x = trk_pos_x;
      if (trk_pos_y < trk_lo_y) trk_lo_y = trk_pos_y;
      if (trk_pos_y > trk_hi_y) trk_hi_y = trk_pos_y;
      // The first motion sample after reset picks the starting direction.
      if (!trk_started) begin
        trk_started = 1'b1;
        trk_rising = (dx + dy) >= 0;
      end
      // Hysteresis test against the extreme of the current sweep.
      if (!trk_rising && longint'(trk_pos_y) > longint'(trk_lo_y) + mg) begin
        trk_rising = 1'b1;
        r.reversed = 1'b1;
        r.extent_x = clamp_s32(-longint'(trk_lo_x));
        r.extent_y = clamp_s32(-longint'(trk_lo_y));
      end else if (trk_rising && longint'(trk_pos_y) < longint'(trk_hi_y) - mg) begin
        trk_rising = 1'b0;
        r.reversed = 1'b1;
        r.extent_x = trk_hi_x;
        r.extent_y = trk_hi_y;
      end
      if (r.reversed) begin
        trk_pos_x = '0;
        trk_pos_y = '0;
        trk_lo_x = '0;
        trk_hi_x = '0;
        trk_lo_y = '0;
        trk_hi_y = '0;
      end
      trk_speed_x = speed_average_next(trk_speed_x, dx, shadow_cfg.avg_shift);
      trk_speed_y = speed_average_next(trk_speed_y, dy, shadow_cfg.avg_shift);
    end
    r.rising_now = trk_rising;
    r.speed_x_avg = trk_speed_x;
    r.speed_y_avg = trk_speed_y;
    return r;
  endfunction

  // Random delta: mostly small strokes, some medium, some full scale and raw.
  function automatic logic signed [15:0] random_delta(input bit negative);
    int mag;
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return 16'($urandom());
    end
    mag = (roll < 60) ? $urandom_range(150) :
          (roll < 85) ? $urandom_range(3000) : $urandom_range(32768);
    if (negative) begin
      return 16'(-mag);
    end
    return (mag > 32767) ? 16'sh7fff : 16'(mag);
  endfunction

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH result %0d %s: got %0d expected %0d",
               results_seen, field, got, want);
    end
    mismatches++;
  endtask

  // Send one item, waiting out random gaps, and record its expected report.
  task automatic send_item(input logic op, input logic signed [15:0] dx,
                           input logic signed [15:0] dy, input bit typed,
                           input res_t want);
    res_t predicted;
    while (!steady_flow && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dy, dx};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = tracker_step(op, dx, dy);
    sweep_reports_due.push_back(typed ? want : predicted);
    if (op == OP_TICK) ticks_sent++;
    else motion_sent++;
  endtask

  // Stop sending and wait until every report has come back.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (sweep_reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MARGIN:      shadow_cfg.margin = value[MARGIN_W-1:0];
      REG_AVG_SHIFT:   shadow_cfg.avg_shift = value[SHIFT_W-1:0];
      REG_DECAY_SHIFT: shadow_cfg.decay_shift = value[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_tracker_config(input int margin, input int avg_sh, input int decay_sh);
    apb_write(REG_MARGIN, 32'(margin));
    apb_write(REG_AVG_SHIFT, 32'(avg_sh));
    apb_write(REG_DECAY_SHIFT, 32'(decay_sh));
    settings_used++;
  endtask

  // Send count full-scale items that push the y position one way.
  task automatic sweep_y(input bit upward, input int count);
    for (int i = 0; i < count; i++) begin
      if (upward) send_item(OP_MOTION, 16'sh7fff, 16'sh8000, 1'b0, '0);
      else send_item(OP_MOTION, 16'sh8000, 16'sh7fff, 1'b0, '0);
    end
  endtask

  // Compare one result transaction with the oldest expected report.
  task automatic check_report();
    res_t got;
    res_t want;
    got.reversed = m_axis_tuser[0];
    got.rising_now = m_axis_tuser[1];
    got.extent_x = m_axis_tdata[31:0];
    got.extent_y = m_axis_tdata[63:32];
    got.speed_x_avg = m_axis_tdata[87:64];
    got.speed_y_avg = m_axis_tdata[111:88];
    if (got.reversed) begin
      reversals_seen++;
      if (got.extent_x == 32'sh7fffffff || got.extent_y == 32'sh7fffffff) begin
        saturated_extents++;
      end
    end
    if (sweep_reports_due.size() == 0) begin
      report_mismatch("unexpected transaction", 0, 0);
    end else begin
      want = sweep_reports_due.pop_front();
      if (got.reversed !== want.reversed)
        report_mismatch("reversed", got.reversed, want.reversed);
      if (got.rising_now !== want.rising_now)
        report_mismatch("rising_now", got.rising_now, want.rising_now);
      if (got.extent_x !== want.extent_x)
        report_mismatch("extent_x", got.extent_x, want.extent_x);
      if (got.extent_y !== want.extent_y)
        report_mismatch("extent_y", got.extent_y, want.extent_y);
      if (got.speed_x_avg !== want.speed_x_avg)
        report_mismatch("speed_x_avg", got.speed_x_avg, want.speed_x_avg);
      if (got.speed_y_avg !== want.speed_y_avg)
        report_mismatch("speed_y_avg", got.speed_y_avg, want.speed_y_avg);
    end
    results_seen++;
  endtask

  // Result side: random backpressure and checking.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_report();
    end
    m_axis_tready <= steady_flow || ($urandom_range(99) >= 21);
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("motion_reversal_tracker_tb failed");
      $finish;
    end
  end

  // Main stimulus sequence.
  initial begin
    int stroke_left;
    bit y_neg;
    logic signed [15:0] rdx;
    logic signed [15:0] rdy;
    stroke_left = 0;
    y_neg = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    shadow_cfg.margin = MARGIN_RST;
    shadow_cfg.avg_shift = AVG_SHIFT_RST;
    shadow_cfg.decay_shift = DECAY_SHIFT_RST;
    {trk_pos_x, trk_pos_y, trk_lo_x, trk_hi_x, trk_lo_y, trk_hi_y} = '0;
    trk_rising = 1'b0;
    trk_started = 1'b0;
    trk_speed_x = '0;
    trk_speed_y = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the register defaults.
    for (int row = 0; row < DIR_ROWS; row++) begin
      send_item(dir_rows[row].op, dir_rows[row].dx, dir_rows[row].dy,
                dir_rows[row].typed, dir_rows[row].want);
    end

    // Random strokes under several register settings, extremes first.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_reports();
      case (phase)
        0: set_tracker_config(0, 0, 0);
        1: set_tracker_config(65535, 15, 15);
        2: set_tracker_config(64, 8, 5);
        default: set_tracker_config($urandom_range(400), $urandom_range(15),
                                    $urandom_range(15));
      endcase
      steady_flow = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 15) begin
          send_item(OP_TICK, 16'($urandom()), 16'($urandom()), 1'b0, '0);
        end else begin
          if (stroke_left == 0) begin
            y_neg = !y_neg;
            stroke_left = $urandom_range(24, 1);
          end
          stroke_left--;
          rdx = random_delta($urandom_range(1));
          rdy = random_delta(y_neg);
          send_item(OP_MOTION, rdx, rdy, 1'b0, '0);
        end
      end
    end
    steady_flow = 1'b0;

    // Full-scale sweeps with the widest margin: the y position climbs in
    // maximum steps, falls back past the margin and climbs again.
    drain_reports();
    set_tracker_config(65535, $urandom_range(15), $urandom_range(15));
    sweep_y(1'b1, SWEEP_ITEMS);
    sweep_y(1'b0, SWEEP_ITEMS);
    sweep_y(1'b1, 4);

    drain_reports();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d motion and %0d tick transactions under %0d register settings.",
             motion_sent, ticks_sent, settings_used);
    $display("Checked %0d results with %0d reversals (%0d with clamped extents).",
             results_seen, reversals_seen, saturated_extents);
    if (mismatches == 0 && sweep_reports_due.size() == 0) begin
      $display("motion_reversal_tracker_tb passed");
    end else begin
      $display("%0d mismatches, %0d reports outstanding", mismatches,
               sweep_reports_due.size());
      $display("motion_reversal_tracker_tb failed");
    end
    $finish;
  end

endmodule
